// ----- rtl/msfs_pkg.sv -----
// ----------------------------------------------------------------------------
// msfs_pkg
// Shared constants and types for the multi-signature format scanner: offset
// widths, byte signatures, verdict codes and combination mask bit positions.
// ----------------------------------------------------------------------------
package msfs_pkg;

  localparam int OFFSET_WIDTH     = 32;
  localparam int OUT_OFFSET_WIDTH = 32;
  localparam int WINDOW_WIDTH     = 32;
  localparam int HIST_BYTES       = 8;
  localparam int HEADER_BYTES     = 4;

  localparam logic [WINDOW_WIDTH-1:0] HTML_WINDOW_RESET = WINDOW_WIDTH'(4096);

  // signatures, first byte in the most significant position
  localparam logic [31:0] SIG_PDF      = 32'h2550_4446;
  localparam logic [31:0] SIG_ZIP      = 32'h504B_0304;
  localparam logic [31:0] SIG_GIF      = 32'h4749_4638;
  localparam logic [23:0] SIG_JPEG     = 24'hFFD8FF;
  localparam logic [71:0] SIG_DOCTYPE  = "<!DOCTYPE";
  localparam logic [39:0] SIG_HTML     = "<html";
  localparam logic [15:0] SIG_SHEBANG  = "#!";
  localparam logic [63:0] SIG_MANIFEST = "Manifest";

  typedef enum logic [1:0] {
    VERDICT_UNKNOWN  = 2'd0,
    VERDICT_SINGLE   = 2'd1,
    VERDICT_POLYGLOT = 2'd2
  } verdict_t;

  localparam int COMBO_PDF_ZIP        = 0;
  localparam int COMBO_GIF_HTML       = 1;
  localparam int COMBO_JPEG_JAR_SHELL = 2;
  localparam int COMBO_JPEG_SHELL     = 3;
  localparam int COMBO_GIF_SHELL      = 4;
  localparam int COMBO_WIDTH          = 5;

  typedef logic [OFFSET_WIDTH-1:0]     offset_t;
  typedef logic [OUT_OFFSET_WIDTH-1:0] out_offset_t;

  function automatic out_offset_t offset_out(input logic valid, input offset_t off);
    out_offset_t res;
    res = valid ? OUT_OFFSET_WIDTH'(off) : '1;
    return res;
  endfunction

endpackage

// ----- rtl/multi_signature_format_scanner.sv -----
// ----------------------------------------------------------------------------
// multi_signature_format_scanner
// Scans a file one byte per item against the PDF, ZIP, Manifest, DOCTYPE and
// html signatures and the GIF, JPEG and shebang magic, and reports offsets,
// flags and a polyglot verdict on the last byte.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   data_byte, last_byte, exec_permission
//   out      output     out_valid/out_stall offsets, flags, count, verdict, mask
//   cfg      input      cfg_we              html_window
//
// One byte is taken every cycle unless the input is stalled; a result appears
// in the cycle after its last byte, limited only by the single result register.
// Reset (synchronous, rst_n low) clears the file state and sets html_window
// to 4096; no clearing pass is needed.
// The input stalls only while a result sits in the result register and the
// output is stalled; a result being taken frees the register in that cycle.
// ----------------------------------------------------------------------------
module multi_signature_format_scanner (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [msfs_pkg::WINDOW_WIDTH-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  input  logic                           in_exec_permission,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [msfs_pkg::OUT_OFFSET_WIDTH-1:0] out_pdf_offset,
  output logic signed [msfs_pkg::OUT_OFFSET_WIDTH-1:0] out_zip_offset,
  output logic                           out_jar_found,
  output logic                           out_gif_found,
  output logic                           out_jpeg_found,
  output logic signed [msfs_pkg::OUT_OFFSET_WIDTH-1:0] out_html_offset,
  output logic                           out_shell_found,
  output logic                           out_executable,
  output logic [2:0]                     out_fmt_count,
  output logic [1:0]                     out_verdict,
  output logic [msfs_pkg::COMBO_WIDTH-1:0] out_combo_mask
);
  import msfs_pkg::*;

  logic [WINDOW_WIDTH-1:0]          html_window_r;
  logic [HIST_BYTES-1:0][7:0]       hist_r;
  logic [HEADER_BYTES-1:0][7:0]     header_r;
  logic [HEADER_BYTES-1:0][7:0]     header_nxt;
  offset_t                          pos_r;
  offset_t                          pos_nxt;
  logic                             pdf_valid_r, zip_valid_r, doctype_valid_r, html_valid_r;
  logic                             pdf_valid_nxt, zip_valid_nxt, doctype_valid_nxt, html_valid_nxt;
  offset_t                          pdf_first_r, zip_first_r, doctype_first_r, html_first_r;
  offset_t                          pdf_first_nxt, zip_first_nxt, doctype_first_nxt, html_first_nxt;
  logic                             manifest_r, manifest_nxt;

  logic [(HIST_BYTES+1)*8-1:0]      win;
  logic                             in_window;
  logic                             accept;
  logic                             pdf_hit, zip_hit, doctype_hit, html_hit;
  logic                             is_gif, is_jpeg, shebang_ok, is_html, is_jar;
  logic [2:0]                       count;
  verdict_t                         verdict;
  logic [COMBO_WIDTH-1:0]           combo;
  out_offset_t                      html_off;

  logic                             out_valid_r;
  out_offset_t                      pdf_off_r, zip_off_r, html_off_r;
  logic                             jar_r, gif_r, jpeg_r, shell_r, exec_r;
  logic [2:0]                       count_r;
  verdict_t                         verdict_r;
  logic [COMBO_WIDTH-1:0]           combo_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // newest byte in the low byte
  assign win       = {hist_r, in_data_byte};
  assign in_window = (OFFSET_WIDTH+WINDOW_WIDTH)'(pos_r) <
                     (OFFSET_WIDTH+WINDOW_WIDTH)'(html_window_r);

  assign pdf_hit     = !pdf_valid_r && (win[31:0] == SIG_PDF);
  assign zip_hit     = !zip_valid_r && (win[31:0] == SIG_ZIP);
  assign doctype_hit = in_window && !doctype_valid_r && (win[71:0] == SIG_DOCTYPE);
  assign html_hit    = in_window && !html_valid_r && (win[39:0] == SIG_HTML);

  assign pdf_valid_nxt     = pdf_valid_r || pdf_hit;
  assign zip_valid_nxt     = zip_valid_r || zip_hit;
  assign doctype_valid_nxt = doctype_valid_r || doctype_hit;
  assign html_valid_nxt    = html_valid_r || html_hit;
  assign pdf_first_nxt     = pdf_hit ? pos_r - OFFSET_WIDTH'(3) : pdf_first_r;
  assign zip_first_nxt     = zip_hit ? pos_r - OFFSET_WIDTH'(3) : zip_first_r;
  assign doctype_first_nxt = doctype_hit ? pos_r - OFFSET_WIDTH'(8) : doctype_first_r;
  assign html_first_nxt    = html_hit ? pos_r - OFFSET_WIDTH'(4) : html_first_r;
  assign manifest_nxt      = manifest_r || (win[63:0] == SIG_MANIFEST);
  assign pos_nxt           = (&pos_r) ? pos_r : pos_r + OFFSET_WIDTH'(1);

  always_comb begin
    header_nxt = header_r;
    if (pos_r[OFFSET_WIDTH-1:2] == '0) begin
      header_nxt[pos_r[1:0]] = in_data_byte;
    end
  end

  // result fields
  assign is_gif     = {header_nxt[0], header_nxt[1], header_nxt[2], header_nxt[3]} == SIG_GIF;
  assign is_jpeg    = {header_nxt[0], header_nxt[1], header_nxt[2]} == SIG_JPEG;
  assign shebang_ok = {header_nxt[0], header_nxt[1]} == SIG_SHEBANG;
  assign is_html    = doctype_valid_nxt || html_valid_nxt;
  assign is_jar     = zip_valid_nxt && manifest_nxt;
  assign html_off   = doctype_valid_nxt ? offset_out(1'b1, doctype_first_nxt)
                                        : offset_out(html_valid_nxt, html_first_nxt);
  assign count      = 3'(pdf_valid_nxt) + 3'(zip_valid_nxt) + 3'(is_gif) +
                      3'(is_jpeg) + 3'(is_html) + 3'(shebang_ok);

  always_comb begin
    combo = '0;
    case (count)
      3'd0:    verdict = VERDICT_UNKNOWN;
      3'd1:    verdict = VERDICT_SINGLE;
      default: verdict = VERDICT_POLYGLOT;
    endcase
    if (verdict == VERDICT_POLYGLOT) begin
      combo[COMBO_PDF_ZIP]        = pdf_valid_nxt && zip_valid_nxt;
      combo[COMBO_GIF_HTML]       = is_gif && is_html;
      combo[COMBO_JPEG_JAR_SHELL] = is_jpeg && is_jar && shebang_ok;
      combo[COMBO_JPEG_SHELL]     = is_jpeg && shebang_ok;
      combo[COMBO_GIF_SHELL]      = is_gif && shebang_ok;
    end
  end

  // configuration and file state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      html_window_r <= HTML_WINDOW_RESET;
    end else if (cfg_we) begin
      html_window_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last_byte)) begin
      hist_r          <= '0;
      header_r        <= '0;
      pos_r           <= '0;
      pdf_valid_r     <= 1'b0;
      zip_valid_r     <= 1'b0;
      doctype_valid_r <= 1'b0;
      html_valid_r    <= 1'b0;
      pdf_first_r     <= '0;
      zip_first_r     <= '0;
      doctype_first_r <= '0;
      html_first_r    <= '0;
      manifest_r      <= 1'b0;
    end else if (accept) begin
      hist_r          <= win[HIST_BYTES*8-1:0];
      header_r        <= header_nxt;
      pos_r           <= pos_nxt;
      pdf_valid_r     <= pdf_valid_nxt;
      zip_valid_r     <= zip_valid_nxt;
      doctype_valid_r <= doctype_valid_nxt;
      html_valid_r    <= html_valid_nxt;
      pdf_first_r     <= pdf_first_nxt;
      zip_first_r     <= zip_first_nxt;
      doctype_first_r <= doctype_first_nxt;
      html_first_r    <= html_first_nxt;
      manifest_r      <= manifest_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last_byte) begin
      pdf_off_r  <= offset_out(pdf_valid_nxt, pdf_first_nxt);
      zip_off_r  <= offset_out(zip_valid_nxt, zip_first_nxt);
      html_off_r <= html_off;
      jar_r      <= is_jar;
      gif_r      <= is_gif;
      jpeg_r     <= is_jpeg;
      shell_r    <= shebang_ok;
      exec_r     <= in_exec_permission;
      count_r    <= count;
      verdict_r  <= verdict;
      combo_r    <= combo;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pdf_offset   = pdf_off_r;
  assign out_zip_offset   = zip_off_r;
  assign out_html_offset  = html_off_r;
  assign out_jar_found    = jar_r;
  assign out_gif_found    = gif_r;
  assign out_jpeg_found   = jpeg_r;
  assign out_shell_found  = shell_r;
  assign out_executable   = exec_r;
  assign out_fmt_count    = count_r;
  assign out_verdict      = verdict_r;
  assign out_combo_mask   = combo_r;

`ifndef SYNTH
  a_new_file_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=> (out_valid && (pos_r == '0) && !manifest_r))
    else $error("file state not cleared after last byte");

  a_verdict_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_verdict == VERDICT_POLYGLOT) == (out_fmt_count >= 3'd2)))
    else $error("verdict disagrees with format count");

  a_combo_polyglot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_verdict != VERDICT_POLYGLOT)) |-> (out_combo_mask == '0))
    else $error("combination mask set without polyglot verdict");

  a_pdf_before_pos: assert property (@(posedge clk) disable iff (!rst_n)
    pdf_valid_r |-> (pdf_first_r < pos_r))
    else $error("pdf offset not behind byte position");
`endif

endmodule
